// File: src/bsfa_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// BN254 scalar field ALU package
// Field constants, widths and the types shared by the ALU modules.
// ============================================================================
package bsfa_pkg;

    localparam int LIMB_W      = 64;
    localparam int TOP_W       = 62;
    localparam int OPC_W       = 2;
    localparam int WORD_W      = 4 * LIMB_W;
    localparam int OPND_W      = 3 * LIMB_W + TOP_W;
    localparam int DIG_W       = 32;
    localparam int NUM_DIG     = WORD_W / DIG_W;
    localparam int ROUNDS      = WORD_W / DIG_W;
    localparam int PROD_W      = 2 * WORD_W;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [WORD_W-1:0] PRIME =
        256'h30644e72e131a029_b85045b68181585d_2833e84879b97091_43e1f593f0000001;

    // -p^-1 mod 2^32, the low digit of the 64-bit Montgomery constant.
    localparam logic [DIG_W-1:0] INV_DIG = 32'hefffffff;

    localparam logic [OPC_W-1:0] OPC_ADD = 2'd0;
    localparam logic [OPC_W-1:0] OPC_SUB = 2'd1;
    localparam logic [OPC_W-1:0] OPC_MUL = 2'd2;

    typedef enum logic [1:0] {
        CLS_ADD,
        CLS_SUB,
        CLS_MUL,
        CLS_ZERO
    } t_op_class;

    typedef struct packed {
        t_op_class         cls;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_queue_head;

    typedef struct packed {
        t_op_class cls;
        logic      borrow;
    } t_tag;

endpackage

// File: src/bsfa_if.sv
`timescale 1ns / 1ps
// ============================================================================
// BN254 scalar field ALU channels
// Request and response channels with valid/ready handshake.
// ============================================================================
interface bsfa_req_if;
    logic                             valid;
    logic                             ready;
    logic [bsfa_pkg::OPC_W-1:0]       opcode;
    logic [bsfa_pkg::LIMB_W-1:0]      a_limb0;
    logic [bsfa_pkg::LIMB_W-1:0]      a_limb1;
    logic [bsfa_pkg::LIMB_W-1:0]      a_limb2;
    logic [bsfa_pkg::TOP_W-1:0]       a_limb3;
    logic [bsfa_pkg::LIMB_W-1:0]      b_limb0;
    logic [bsfa_pkg::LIMB_W-1:0]      b_limb1;
    logic [bsfa_pkg::LIMB_W-1:0]      b_limb2;
    logic [bsfa_pkg::TOP_W-1:0]       b_limb3;

    modport source (output valid, opcode, a_limb0, a_limb1, a_limb2, a_limb3,
                    b_limb0, b_limb1, b_limb2, b_limb3, input ready);
    modport sink   (input valid, opcode, a_limb0, a_limb1, a_limb2, a_limb3,
                    b_limb0, b_limb1, b_limb2, b_limb3, output ready);
endinterface

interface bsfa_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [bsfa_pkg::LIMB_W-1:0]      r_limb0;
    logic [bsfa_pkg::LIMB_W-1:0]      r_limb1;
    logic [bsfa_pkg::LIMB_W-1:0]      r_limb2;
    logic [bsfa_pkg::TOP_W-1:0]       r_limb3;

    modport source (output valid, r_limb0, r_limb1, r_limb2, r_limb3, input ready);
    modport sink   (input valid, r_limb0, r_limb1, r_limb2, r_limb3, output ready);
endinterface

// File: src/bsfa_front.sv
`timescale 1ns / 1ps
// ============================================================================
// BN254 scalar field ALU front end
// Accepts items, classifies the opcode and queues them for the datapath.
// ============================================================================
module bsfa_front #(
    parameter int QUEUE_DEPTH = bsfa_pkg::QUEUE_DEPTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    bsfa_req_if.sink               i_req,
    input  logic                   i_pop,
    output bsfa_pkg::t_queue_head  o_head
);
    import bsfa_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_item            r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    t_op_class        w_cls;
    t_item            w_item;
    logic             w_push;
    logic             w_pop;

    always_comb begin
        case (i_req.opcode)
            OPC_ADD: w_cls = CLS_ADD;
            OPC_SUB: w_cls = CLS_SUB;
            OPC_MUL: w_cls = CLS_MUL;
            default: w_cls = CLS_ZERO;
        endcase
    end

    assign w_item.cls = w_cls;
    assign w_item.a   = {{(WORD_W-OPND_W){1'b0}}, i_req.a_limb3, i_req.a_limb2,
                         i_req.a_limb1, i_req.a_limb0};
    assign w_item.b   = {{(WORD_W-OPND_W){1'b0}}, i_req.b_limb3, i_req.b_limb2,
                         i_req.b_limb1, i_req.b_limb0};

    assign i_req.ready = (r_count != CNT_W'(QUEUE_DEPTH));
    assign w_push      = i_req.valid && i_req.ready;
    assign w_pop       = i_pop && (r_count != '0);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_item;
        end
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.item  = r_mem[r_rd_ptr];

endmodule

// File: src/bsfa_redc_round.sv
`timescale 1ns / 1ps
// ============================================================================
// BN254 scalar field ALU reduction round
// One 32-bit Montgomery reduction step over three pipeline stages.
// ============================================================================
module bsfa_redc_round (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  bsfa_pkg::t_tag                i_tag,
    input  logic [bsfa_pkg::PROD_W-1:0]   i_t,
    output bsfa_pkg::t_tag                o_tag,
    output logic [bsfa_pkg::PROD_W-1:0]   o_t
);
    import bsfa_pkg::*;

    logic [DIG_W-1:0]    r_k;
    logic [PROD_W-1:0]   r_t1, r_t2, r_t3;
    t_tag                r_tag1, r_tag2, r_tag3;
    logic [2*DIG_W-1:0]  r_kpp [NUM_DIG];
    logic [2*DIG_W-1:0]  w_kinv;
    logic [WORD_W-1:0]   w_even, w_odd;
    logic [PROD_W:0]     w_sum;

    assign w_kinv = i_t[DIG_W-1:0] * INV_DIG;

    always_comb begin
        for (int j = 0; j < NUM_DIG / 2; j++) begin
            w_even[2*DIG_W*j +: 2*DIG_W] = r_kpp[2*j];
            w_odd[2*DIG_W*j +: 2*DIG_W]  = r_kpp[2*j+1];
        end
    end

    // Adding k*p clears the low digit, so the shift is exact.
    assign w_sum = {1'b0, r_t2} + (PROD_W+1)'(w_even)
                 + ((PROD_W+1)'(w_odd) << DIG_W);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_k    <= w_kinv[DIG_W-1:0];
            r_t1   <= i_t;
            r_tag1 <= i_tag;
            for (int j = 0; j < NUM_DIG; j++) begin
                r_kpp[j] <= r_k * PRIME[DIG_W*j +: DIG_W];
            end
            r_t2   <= r_t1;
            r_tag2 <= r_tag1;
            r_t3   <= (r_tag2.cls == CLS_MUL) ? PROD_W'(w_sum >> DIG_W) : r_t2;
            r_tag3 <= r_tag2;
        end
    end

    assign o_t   = r_t3;
    assign o_tag = r_tag3;

endmodule

// File: src/bsfa_back.sv
`timescale 1ns / 1ps
// ============================================================================
// BN254 scalar field ALU back end
// Pipelined add, subtract and Montgomery multiply with final correction.
// ============================================================================
module bsfa_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  bsfa_pkg::t_queue_head  i_head,
    output logic                   o_pop,
    bsfa_rsp_if.source             o_rsp
);
    import bsfa_pkg::*;

    localparam int PP_W       = 2 * DIG_W;
    localparam int ROW_W      = WORD_W + DIG_W;
    localparam int PAIR_W     = ROW_W + DIG_W;
    localparam int QUAD_W     = PAIR_W + 2 * DIG_W;
    localparam int NUM_STAGES = 5 + 3 * ROUNDS;

    logic                  w_en;
    logic [NUM_STAGES-1:0] r_valid;
    logic                  r_out_valid;

    logic [PP_W-1:0]   r_pp [NUM_DIG][NUM_DIG];
    logic [ROW_W-1:0]  r_row [NUM_DIG];
    logic [PAIR_W-1:0] r_pair [NUM_DIG/2];
    logic [QUAD_W-1:0] r_quad [2];
    logic [WORD_W-1:0] r_t0, r_t1, r_t2, r_t3;
    t_tag              r_tag0, r_tag1, r_tag2, r_tag3, r_tag4;
    logic [PROD_W-1:0] r_t4;
    logic [OPND_W-1:0] r_res;

    logic [WORD_W:0]   w_add, w_sub;
    logic [WORD_W-1:0] w_even [NUM_DIG];
    logic [WORD_W-1:0] w_odd [NUM_DIG];
    logic [PROD_W-1:0] w_prod;
    logic [PROD_W-1:0] w_rt [ROUNDS+1];
    t_tag              w_rtag [ROUNDS+1];
    logic [WORD_W-1:0] w_lo, w_fix_add;
    logic [WORD_W:0]   w_fix_sub;
    logic [WORD_W-1:0] w_res;

    assign w_en  = !r_out_valid || o_rsp.ready;
    assign o_pop = w_en && i_head.valid;

    assign w_add = {1'b0, i_head.item.a} + {1'b0, i_head.item.b};
    assign w_sub = {1'b0, i_head.item.a} - {1'b0, i_head.item.b};

    always_comb begin
        for (int j = 0; j < NUM_DIG; j++) begin
            for (int i = 0; i < NUM_DIG / 2; i++) begin
                w_even[j][PP_W*i +: PP_W] = r_pp[2*i][j];
                w_odd[j][PP_W*i +: PP_W]  = r_pp[2*i+1][j];
            end
        end
    end

    assign w_prod = PROD_W'(r_quad[0]) + (PROD_W'(r_quad[1]) << (4 * DIG_W));

    // Partial product matrix and row, pair and quad sums of a*b, with the add or subtract result carried alongside.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < NUM_DIG; i++) begin
                for (int j = 0; j < NUM_DIG; j++) begin
                    r_pp[i][j] <= i_head.item.a[DIG_W*i +: DIG_W]
                                * i_head.item.b[DIG_W*j +: DIG_W];
                end
            end
            r_tag0.cls    <= i_head.item.cls;
            r_tag0.borrow <= w_sub[WORD_W];
            r_t0          <= (i_head.item.cls == CLS_SUB) ? w_sub[WORD_W-1:0]
                                                          : w_add[WORD_W-1:0];
            for (int j = 0; j < NUM_DIG; j++) begin
                r_row[j] <= ROW_W'(w_even[j]) + (ROW_W'(w_odd[j]) << DIG_W);
            end
            r_t1   <= r_t0;
            r_tag1 <= r_tag0;
            for (int k = 0; k < NUM_DIG / 2; k++) begin
                r_pair[k] <= PAIR_W'(r_row[2*k]) + (PAIR_W'(r_row[2*k+1]) << DIG_W);
            end
            r_t2   <= r_t1;
            r_tag2 <= r_tag1;
            for (int m = 0; m < 2; m++) begin
                r_quad[m] <= QUAD_W'(r_pair[2*m])
                           + (QUAD_W'(r_pair[2*m+1]) << (2 * DIG_W));
            end
            r_t3   <= r_t2;
            r_tag3 <= r_tag2;
            r_t4   <= (r_tag3.cls == CLS_MUL) ? w_prod : PROD_W'(r_t3);
            r_tag4 <= r_tag3;
        end
    end

    assign w_rt[0]   = r_t4;
    assign w_rtag[0] = r_tag4;

    for (genvar g = 0; g < ROUNDS; g++) begin : g_round
        bsfa_redc_round u_round (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_tag (w_rtag[g]),
            .i_t   (w_rt[g]),
            .o_tag (w_rtag[g+1]),
            .o_t   (w_rt[g+1])
        );
    end

    assign w_lo      = w_rt[ROUNDS][WORD_W-1:0];
    assign w_fix_sub = {1'b0, w_lo} - {1'b0, PRIME};
    assign w_fix_add = w_lo + PRIME;

    always_comb begin
        case (w_rtag[ROUNDS].cls)
            CLS_ADD, CLS_MUL: w_res = w_fix_sub[WORD_W] ? w_lo : w_fix_sub[WORD_W-1:0];
            CLS_SUB:          w_res = w_rtag[ROUNDS].borrow ? w_fix_add : w_lo;
            default:          w_res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_res <= w_res[OPND_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_valid     <= {r_valid[NUM_STAGES-2:0], i_head.valid};
            r_out_valid <= r_valid[NUM_STAGES-1];
        end
    end

    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.r_limb0 = r_res[LIMB_W-1:0];
    assign o_rsp.r_limb1 = r_res[2*LIMB_W-1:LIMB_W];
    assign o_rsp.r_limb2 = r_res[3*LIMB_W-1:2*LIMB_W];
    assign o_rsp.r_limb3 = r_res[OPND_W-1:3*LIMB_W];

endmodule

// File: src/bn254_scalar_field_alu.sv
`timescale 1ns / 1ps
// ============================================================================
// BN254 scalar field ALU
// Add, subtract and Montgomery multiply modulo the BN254 scalar field prime.
// ============================================================================
// The unit takes one item per clock while the output is not stalled. The
// pipeline depth is set by the Montgomery path: one stage of 32x32 partial
// products, four adder-tree stages, and eight 32-bit reduction rounds of
// three stages each, then a final correction by p that also serves the add
// and subtract items. Add and subtract travel the same pipe, so results
// leave in acceptance order. Opcode 3 yields zero. A stalled output freezes
// the pipe; the two-entry queue fills before the input stalls as well.
module bn254_scalar_field_alu #(
    parameter int QUEUE_DEPTH = bsfa_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bsfa_req_if.sink    i_req,
    bsfa_rsp_if.source  o_rsp
);
    import bsfa_pkg::*;

    t_queue_head w_head;
    logic        w_pop;

    bsfa_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_pop   (w_pop),
        .o_head  (w_head)
    );

    bsfa_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_rsp   (o_rsp)
    );

endmodule

// File: src/bsfa_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// BN254 scalar field ALU checker
// Port-level assertions on reset behavior and the response channel.
// ============================================================================
module bsfa_assertions (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_req_ready,
    input  logic                              i_rsp_valid,
    input  logic                              i_rsp_ready,
    input  logic [bsfa_pkg::OPND_W-1:0]       i_rsp_data
);
    import bsfa_pkg::*;

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_data))
        else $error("response changed while stalled");

    a_rst_no_rsp: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("response valid right after reset");

    a_rst_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> i_req_ready)
        else $error("queue not ready right after reset");

endmodule

bind bn254_scalar_field_alu bsfa_assertions u_bsfa_assertions (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_data  ({o_rsp.r_limb3, o_rsp.r_limb2, o_rsp.r_limb1, o_rsp.r_limb0})
);
